### rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constant tables for the seven-segment time display encoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int VALUE_W = 16;
  localparam int SAT_W   = 14;
  localparam int LINES_W = 48;

  localparam logic [SAT_W-1:0] VALUE_MAX = 14'd9999;

  // v / 100 == (v * 5243) >> 19 for every v up to 9999
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // x / 10 == (x * 205) >> 11 for every x up to 99
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int          DIV10_SHIFT  = 11;

  // front result: saturated value split into hundreds and remainder
  typedef struct packed {
    logic [6:0] hundreds;
    logic [6:0] rest;
    logic       colon_dot;
    logic       pm_on;
  } front_item_t;

  // one spot on the glass: bit {addr, com} of the flat line image
  typedef struct packed {
    logic       wired;
    logic [3:0] addr;
    logic [1:0] com;
  } glass_pos_t;

  // segments a..g in bits 0..6
  localparam logic [6:0] SEG_PATTERNS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // [digit][segment a..g], digit 3 is the leftmost
  localparam glass_pos_t GLASS_MAP [4][7] = '{
    '{'{1'b1, 4'd10, 2'd3}, '{1'b1, 4'd10, 2'd2}, '{1'b1, 4'd10, 2'd1},
      '{1'b1, 4'd9, 2'd1},  '{1'b1, 4'd8, 2'd1},  '{1'b1, 4'd9, 2'd3},
      '{1'b1, 4'd9, 2'd2}},
    '{'{1'b1, 4'd8, 2'd2},  '{1'b1, 4'd7, 2'd3},  '{1'b1, 4'd7, 2'd1},
      '{1'b1, 4'd6, 2'd1},  '{1'b1, 4'd6, 2'd2},  '{1'b1, 4'd6, 2'd3},
      '{1'b1, 4'd7, 2'd2}},
    '{'{1'b1, 4'd4, 2'd3},  '{1'b1, 4'd5, 2'd2},  '{1'b1, 4'd5, 2'd1},
      '{1'b1, 4'd4, 2'd1},  '{1'b1, 4'd3, 2'd1},  '{1'b1, 4'd3, 2'd2},
      '{1'b1, 4'd4, 2'd2}},
    '{'{1'b0, 4'd0, 2'd0},  '{1'b1, 4'd2, 2'd2},  '{1'b1, 4'd2, 2'd1},
      '{1'b0, 4'd0, 2'd0},  '{1'b0, 4'd0, 2'd0},  '{1'b0, 4'd0, 2'd0},
      '{1'b1, 4'd1, 2'd2}}
  };

  localparam glass_pos_t COLON_POS = '{1'b1, 4'd8, 2'd3};
  localparam glass_pos_t PM_POS    = '{1'b1, 4'd3, 2'd3};

endpackage

### rtl/ssd_in_if.sv
// ----------------------------------------------------------------------------
// ssd_in_if
// Input channel: value to show with colon and pm flags.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssd_pkg::VALUE_W-1:0] value;
  logic                        colon_dot;
  logic                        pm_on;

  modport source (output valid, output value, output colon_dot, output pm_on,
                  input ready);
  modport sink   (input valid, input value, input colon_dot, input pm_on,
                  output ready);
endinterface

### rtl/ssd_out_if.sv
// ----------------------------------------------------------------------------
// ssd_out_if
// Result channel: six lcd memory bytes for lines 8 to 19.
// ----------------------------------------------------------------------------
interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lines_8_9;
  logic [7:0] lines_10_11;
  logic [7:0] lines_12_13;
  logic [7:0] lines_14_15;
  logic [7:0] lines_16_17;
  logic [7:0] lines_18_19;

  modport source (output valid, output lines_8_9, output lines_10_11,
                  output lines_12_13, output lines_14_15, output lines_16_17,
                  output lines_18_19, input ready);
  modport sink   (input valid, input lines_8_9, input lines_10_11,
                  input lines_12_13, input lines_14_15, input lines_16_17,
                  input lines_18_19, output ready);
endinterface

### rtl/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts items, saturates the value and splits it into hundreds and rest.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                clk,
  input  logic                rst_n,
  ssd_in_if.sink              in_if,
  output logic                fr_valid,
  output ssd_pkg::front_item_t fr_item,
  input  logic                fr_ready
);

  logic                        vld_r;
  ssd_pkg::front_item_t        item_r;
  ssd_pkg::front_item_t        item_nxt;
  logic [ssd_pkg::SAT_W-1:0]   v_sat;
  logic [26:0]                 prod;
  logic [6:0]                  hund;
  logic [ssd_pkg::SAT_W-1:0]   hund_x100;
  logic [ssd_pkg::SAT_W-1:0]   rem;

  assign in_if.ready = !vld_r || fr_ready;

  always_comb begin
    if (in_if.value > 16'(ssd_pkg::VALUE_MAX)) begin
      v_sat = ssd_pkg::VALUE_MAX;
    end else begin
      v_sat = in_if.value[ssd_pkg::SAT_W-1:0];
    end
    prod      = 27'(v_sat) * 27'(ssd_pkg::DIV100_MUL);
    hund      = prod[ssd_pkg::DIV100_SHIFT +: 7];
    // x100 as shift-add
    hund_x100 = (14'(hund) << 6) + (14'(hund) << 5) + (14'(hund) << 2);
    rem       = v_sat - hund_x100;
    item_nxt.hundreds  = hund;
    item_nxt.rest      = rem[6:0];
    item_nxt.colon_dot = in_if.colon_dot;
    item_nxt.pm_on     = in_if.pm_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_if.ready) begin
      vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r <= item_nxt;
    end
  end

  assign fr_valid = vld_r;
  assign fr_item  = item_r;

endmodule

### rtl/ssd_fifo.sv
// ----------------------------------------------------------------------------
// ssd_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ssd_pkg::front_item_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ssd_pkg::front_item_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssd_pkg::front_item_t mem_r [DEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r;
  logic [PW-1:0]        rd_ptr_nxt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 push;
  logic                 pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Splits into digits, blanks leading zeros, routes segments onto the glass.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bk_valid,
  output logic                 bk_ready,
  input  ssd_pkg::front_item_t bk_item,
  ssd_out_if.source            out_if
);

  logic                          out_vld_r;
  logic [ssd_pkg::LINES_W-1:0]   lines_r;
  logic [ssd_pkg::LINES_W-1:0]   lines_nxt;
  logic [14:0]                   hi_prod;
  logic [14:0]                   lo_prod;
  logic [3:0]                    dig [4];
  logic [6:0]                    hi_tens;
  logic [6:0]                    lo_tens;
  logic [3:0]                    show;
  ssd_pkg::glass_pos_t           pos;

  assign bk_ready = !out_vld_r || out_if.ready;

  always_comb begin
    hi_prod = 15'(bk_item.hundreds) * 15'(ssd_pkg::DIV10_MUL);
    lo_prod = 15'(bk_item.rest) * 15'(ssd_pkg::DIV10_MUL);
    dig[3]  = hi_prod[ssd_pkg::DIV10_SHIFT +: 4];
    dig[1]  = lo_prod[ssd_pkg::DIV10_SHIFT +: 4];
    hi_tens = (7'(dig[3]) << 3) + (7'(dig[3]) << 1);
    lo_tens = (7'(dig[1]) << 3) + (7'(dig[1]) << 1);
    dig[2]  = 4'(bk_item.hundreds - hi_tens);
    dig[0]  = 4'(bk_item.rest - lo_tens);

    // leading zero blanking, right digit always shown
    show[3] = (dig[3] != '0);
    show[2] = show[3] || (dig[2] != '0);
    show[1] = show[2] || (dig[1] != '0);
    show[0] = 1'b1;

    lines_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      for (int s = 0; s < 7; s++) begin
        pos = ssd_pkg::GLASS_MAP[k][s];
        if (pos.wired && show[k] && ssd_pkg::SEG_PATTERNS[dig[k]][s]) begin
          lines_nxt[{pos.addr, pos.com}] = 1'b1;
        end
      end
    end
    if (bk_item.colon_dot) begin
      lines_nxt[{ssd_pkg::COLON_POS.addr, ssd_pkg::COLON_POS.com}] = 1'b1;
    end
    if (bk_item.pm_on) begin
      lines_nxt[{ssd_pkg::PM_POS.addr, ssd_pkg::PM_POS.com}] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (bk_ready) begin
      out_vld_r <= bk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_valid && bk_ready) begin
      lines_r <= lines_nxt;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.lines_8_9   = lines_r[7:0];
  assign out_if.lines_10_11 = lines_r[15:8];
  assign out_if.lines_12_13 = lines_r[23:16];
  assign out_if.lines_14_15 = lines_r[31:24];
  assign out_if.lines_16_17 = lines_r[39:32];
  assign out_if.lines_18_19 = lines_r[47:40];

endmodule

### rtl/seven_segment_time_display_encoder.sv
// ----------------------------------------------------------------------------
// seven_segment_time_display_encoder
// Four-digit value to lcd memory image for lines 8 to 19, with colon and pm.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake     | payload
//   in_if    | in  | valid / ready | value[15:0], colon_dot, pm_on
//   out_if   | out | valid / ready | lines_8_9 .. lines_18_19, 8 bits each
//
// one item per cycle sustained while neither side stalls; a result passes
// the front register (loaded at accept), the queue, then the output register
// the divide-by-100 multiply in the front and the digit split in the back
// each take one register stage
// rst_n clears the valid flags, queue pointers and queue count only
// either side may stall; the queue of QUEUE_DEPTH entries absorbs it
// ----------------------------------------------------------------------------
module seven_segment_time_display_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_if,
  ssd_out_if.source out_if
);

  logic                 fr_valid;
  logic                 fr_ready;
  ssd_pkg::front_item_t fr_item;
  logic                 bk_valid;
  logic                 bk_ready;
  ssd_pkg::front_item_t bk_item;

  ssd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .fr_valid (fr_valid),
    .fr_item  (fr_item),
    .fr_ready (fr_ready)
  );

  ssd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_item)
  );

  ssd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bk_valid (bk_valid),
    .bk_ready (bk_ready),
    .bk_item  (bk_item),
    .out_if   (out_if)
  );

  // split of a saturated value stays in range
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid |-> (fr_item.hundreds < 7'd100) && (fr_item.rest < 7'd100))
    else $error("front split out of range");

  // line 8 and line 19 are never driven
  a_unused_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.lines_8_9[3:0] == 4'h0) &&
                     (out_if.lines_18_19[7:4] == 4'h0))
    else $error("unused line lit");

  // common 0 is never used by the glass
  a_common0: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> ((out_if.lines_8_9 & 8'h11) == 8'h00) &&
                     ((out_if.lines_10_11 & 8'h11) == 8'h00) &&
                     ((out_if.lines_12_13 & 8'h11) == 8'h00) &&
                     ((out_if.lines_14_15 & 8'h11) == 8'h00) &&
                     ((out_if.lines_16_17 & 8'h11) == 8'h00) &&
                     ((out_if.lines_18_19 & 8'h11) == 8'h00))
    else $error("common 0 bit set");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && !bk_valid)
    else $error("valid after reset");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the seven-segment time display encoder against its own image
// predictor. Values, colon and pm flags go in through the input channel.
// Each lcd memory image that comes out is compared byte by byte with the
// image predicted for the oldest accepted input. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_ITEMS   = 200;
  localparam int BLOCK_ITEMS  = 150;

  // glass position of each segment a..g per digit; address 0 is not wired
  localparam int GLASS_ADDR [4][7] = '{
    '{10, 10, 10, 9, 8, 9, 9},
    '{ 8,  7,  7, 6, 6, 6, 7},
    '{ 4,  5,  5, 4, 3, 3, 4},
    '{ 0,  2,  2, 0, 0, 0, 1}
  };
  localparam int GLASS_COM [4][7] = '{
    '{3, 2, 1, 1, 1, 3, 2},
    '{2, 3, 1, 1, 2, 3, 2},
    '{3, 2, 1, 1, 1, 2, 2},
    '{0, 2, 1, 0, 0, 0, 2}
  };
  localparam bit [6:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  // bit index in the flat image of lines 8..19 is address * 4 + common
  localparam int COLON_BIT = 8 * 4 + 3;
  localparam int PM_BIT    = 3 * 4 + 3;
  localparam int SHOW_MAX  = 9999;

  typedef struct packed {
    logic [7:0] lines_8_9;
    logic [7:0] lines_10_11;
    logic [7:0] lines_12_13;
    logic [7:0] lines_14_15;
    logic [7:0] lines_16_17;
    logic [7:0] lines_18_19;
  } lcd_image_t;

  class lcd_image_board;
    lcd_image_t pending_images[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function lcd_image_t render_image(logic [15:0] value, logic colon_dot,
                                      logic pm_on);
      int unsigned shown_val;
      int unsigned dig[4];
      bit          lit[4];
      logic [47:0] flat;
      lcd_image_t  img;
      shown_val = 32'(value);
      if (shown_val > SHOW_MAX) shown_val = SHOW_MAX;
      dig[0] = shown_val % 10;
      dig[1] = (shown_val / 10) % 10;
      dig[2] = (shown_val / 100) % 10;
      dig[3] = (shown_val / 1000) % 10;
      // leading zero blanking, the rightmost digit always shows
      lit[3] = (dig[3] != 0);
      lit[2] = lit[3] || (dig[2] != 0);
      lit[1] = lit[2] || (dig[1] != 0);
      lit[0] = 1'b1;
      flat = '0;
      for (int k = 0; k < 4; k++) begin
        for (int s = 0; s < 7; s++) begin
          if (lit[k] && DIGIT_SEGS[dig[k]][s] && GLASS_ADDR[k][s] != 0) begin
            flat[GLASS_ADDR[k][s] * 4 + GLASS_COM[k][s]] = 1'b1;
          end
        end
      end
      if (colon_dot) flat[COLON_BIT] = 1'b1;
      if (pm_on) flat[PM_BIT] = 1'b1;
      img.lines_8_9   = flat[7:0];
      img.lines_10_11 = flat[15:8];
      img.lines_12_13 = flat[23:16];
      img.lines_14_15 = flat[31:24];
      img.lines_16_17 = flat[39:32];
      img.lines_18_19 = flat[47:40];
      return img;
    endfunction

    function void note_value(logic [15:0] value, logic colon_dot, logic pm_on);
      pending_images.push_back(render_image(value, colon_dot, pm_on));
    endfunction

    function int pending();
      return pending_images.size();
    endfunction

    function void compare_byte(string field, logic [7:0] exp_b, logic [7:0] got_b);
      if (got_b !== exp_b) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h actual %02h", $time, field,
                 exp_b, got_b);
      end
    endfunction

    function void check_image(lcd_image_t got);
      lcd_image_t exp_img;
      if (pending_images.size() == 0) begin
        errors++;
        $display("%0t: unexpected image, expected none actual %012h", $time, got);
        return;
      end
      exp_img = pending_images.pop_front();
      compare_byte("lines_8_9", exp_img.lines_8_9, got.lines_8_9);
      compare_byte("lines_10_11", exp_img.lines_10_11, got.lines_10_11);
      compare_byte("lines_12_13", exp_img.lines_12_13, got.lines_12_13);
      compare_byte("lines_14_15", exp_img.lines_14_15, got.lines_14_15);
      compare_byte("lines_16_17", exp_img.lines_16_17, got.lines_16_17);
      compare_byte("lines_18_19", exp_img.lines_18_19, got.lines_18_19);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;

  lcd_image_board board = new();

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  seven_segment_time_display_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int burst;
    int hold_count;
    lcd_image_t got;
    burst = 0;
    hold_count = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.lines_8_9   = out_ch.lines_8_9;
        got.lines_10_11 = out_ch.lines_10_11;
        got.lines_12_13 = out_ch.lines_12_13;
        got.lines_14_15 = out_ch.lines_14_15;
        got.lines_16_17 = out_ch.lines_16_17;
        got.lines_18_19 = out_ch.lines_18_19;
        board.check_image(got);
      end
      if (hold_req) begin
        hold_count = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer_item(input logic [15:0] value, input logic colon_dot,
                            input logic pm_on);
    in_ch.valid     <= 1'b1;
    in_ch.value     <= value;
    in_ch.colon_dot <= colon_dot;
    in_ch.pm_on     <= pm_on;
    do @(posedge clk); while (!in_ch.ready);
    board.note_value(value, colon_dot, pm_on);
  endtask

  task automatic maybe_gap();
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid     <= 1'b0;
      in_ch.value     <= 16'($urandom_range(0, 65535));
      in_ch.colon_dot <= 1'($urandom_range(0, 1));
      in_ch.pm_on     <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(0, 99));
      2:       return 16'($urandom_range(0, 999));
      3:       return 16'($urandom_range(SHOW_MAX + 1, 65535));
      4:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, SHOW_MAX));
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] corner_vals[$];
    int guard;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.colon_dot <= 1'b0;
    in_ch.pm_on     <= 1'b0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // blanking edges, every digit in every place, saturation
    corner_vals = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                    16'd1000, 16'd1005, 16'd9000, 16'd9999, 16'd10000,
                    16'd65535, 16'd32768};
    for (int k = 1; k <= 9; k++) corner_vals.push_back(16'(1111 * k));
    foreach (corner_vals[i]) begin
      offer_item(corner_vals[i], i[0], i[1]);
      maybe_gap();
    end
    offer_item(16'd0, 1'b1, 1'b1);
    drain_results();

    // receiver holds off while items keep coming, so the input stalls
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      offer_item(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ((i / BLOCK_ITEMS) % 3 != 2);
      end
      if (i == RANDOM_ITEMS / 2) drain_results();
      offer_item(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      maybe_gap();
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (board.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d images never arrived, expected none left actual %0d",
               $time, board.pending(), board.pending());
    end
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
